// ----- rtl/tlrq_pkg.sv -----
// Shared types, codes and helpers for the three-level ready queue scheduler.
package tlrq_pkg;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_PICK   = 2'd1,
        KIND_AGE    = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    // Level codes as they appear on the picked_level output.
    localparam logic [1:0] LVL_NONE  = 2'd0;
    localparam logic [1:0] LVL_ONE   = 2'd1;
    localparam logic [1:0] LVL_TWO   = 2'd2;
    localparam logic [1:0] LVL_THREE = 2'd3;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_L2_FLOOR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_L1_FLOOR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOST     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CAP       = 3'd4;

    localparam logic [7:0]  RST_L2_FLOOR  = 8'd50;
    localparam logic [7:0]  RST_L1_FLOOR  = 8'd100;
    localparam logic [15:0] RST_THRESHOLD = 16'd1500;
    localparam logic [7:0]  RST_BOOST     = 8'd10;
    localparam logic [7:0]  RST_CAP       = 8'd149;

    typedef struct packed {
        logic [15:0] task_id;
        logic [7:0]  prio;
        logic [31:0] burst;
        logic [31:0] enter;
        logic [31:0] wait_acc;
        logic [15:0] arrival;
    } t_entry;

    typedef struct packed {
        logic accept;
        logic idx_inc;
        logic scan_start;
        logic scan_step;
        logic ins_write;
        logic set_full;
        logic pick_take;
        logic age_calc;
        logic age_write;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic  slot_free;
        logic  idx_last;
        logic  best_hit;
        t_kind kind;
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_SCAN,
        S_INS_WR,
        S_SCAN,
        S_DRAIN,
        S_PICK_TAKE,
        S_AGE_CALC,
        S_AGE_WR,
        S_DONE
    } t_state;

    function automatic logic [1:0] level_of(input logic [7:0] prio,
                                            input logic [7:0] l2_floor,
                                            input logic [7:0] l1_floor);
        logic [1:0] lvl;
        if (prio < l2_floor) begin
            lvl = LVL_THREE;
        end else if (prio < l1_floor) begin
            lvl = LVL_TWO;
        end else begin
            lvl = LVL_ONE;
        end
        return lvl;
    endfunction

endpackage

// ----- rtl/tlrq_ctrl.sv -----
// Sequencer for insert, pick and aging requests.
module tlrq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [1:0]         i_kind,
    input  tlrq_pkg::t_status  i_stat,
    output tlrq_pkg::t_cmd     o_cmd,
    output logic               o_busy
);

    tlrq_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tlrq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            tlrq_pkg::S_IDLE: begin
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    unique case (tlrq_pkg::t_kind'(i_kind)) inside
                        tlrq_pkg::KIND_INSERT: n_state = tlrq_pkg::S_INS_SCAN;
                        tlrq_pkg::KIND_PICK, tlrq_pkg::KIND_AGE: n_state = tlrq_pkg::S_SCAN;
                        default: n_state = tlrq_pkg::S_DONE;
                    endcase
                end
            end
            tlrq_pkg::S_INS_SCAN: begin
                if (i_stat.slot_free) begin
                    n_state = tlrq_pkg::S_INS_WR;
                end else if (i_stat.idx_last) begin
                    o_cmd.set_full = 1'b1;
                    n_state = tlrq_pkg::S_DONE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            tlrq_pkg::S_INS_WR: begin
                o_cmd.ins_write = 1'b1;
                n_state = tlrq_pkg::S_DONE;
            end
            tlrq_pkg::S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.idx_last) begin
                    n_state = tlrq_pkg::S_DRAIN;
                end
            end
            tlrq_pkg::S_DRAIN: begin
                // The last read compares in this cycle.
                if (i_stat.kind == tlrq_pkg::KIND_PICK) begin
                    n_state = tlrq_pkg::S_PICK_TAKE;
                end else begin
                    n_state = tlrq_pkg::S_AGE_CALC;
                end
            end
            tlrq_pkg::S_PICK_TAKE: begin
                o_cmd.pick_take = 1'b1;
                n_state = tlrq_pkg::S_DONE;
            end
            tlrq_pkg::S_AGE_CALC: begin
                if (i_stat.best_hit) begin
                    o_cmd.age_calc = 1'b1;
                    n_state = tlrq_pkg::S_AGE_WR;
                end else begin
                    n_state = tlrq_pkg::S_DONE;
                end
            end
            tlrq_pkg::S_AGE_WR: begin
                o_cmd.age_write  = 1'b1;
                o_cmd.scan_start = 1'b1;
                n_state = tlrq_pkg::S_SCAN;
            end
            tlrq_pkg::S_DONE: begin
                o_cmd.emit = 1'b1;
                n_state = tlrq_pkg::S_IDLE;
            end
            default: n_state = tlrq_pkg::S_IDLE;
        endcase
    end

    assign o_busy = (r_state != tlrq_pkg::S_IDLE);

endmodule

// ----- rtl/tlrq_dp.sv -----
// Slot table, scan compare, aging arithmetic and result registers.
module tlrq_dp #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tlrq_pkg::t_cmd                    i_cmd,
    output tlrq_pkg::t_status                 o_stat,
    input  logic                              i_cfg_we,
    input  logic [tlrq_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [tlrq_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic [1:0]                        i_kind,
    input  logic [15:0]                       i_task_id,
    input  logic [7:0]                        i_task_priority,
    input  logic [31:0]                       i_burst_estimate,
    input  logic [31:0]                       i_wait_so_far,
    input  logic [31:0]                       i_now,
    input  logic [7:0]                        i_running_priority,
    input  logic [31:0]                       i_running_burst,
    output logic                              o_done,
    output logic                              o_found,
    output logic [15:0]                       o_picked_id,
    output logic [7:0]                        o_picked_priority,
    output logic [31:0]                       o_picked_wait,
    output logic [1:0]                        o_picked_level,
    output logic                              o_preempt,
    output logic                              o_table_full
);

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(QUEUE_DEPTH - 1);

    // Configuration registers.
    logic [7:0]  r_l2f, r_l1f, r_boost, r_cap;
    logic [15:0] r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l2f   <= tlrq_pkg::RST_L2_FLOOR;
            r_l1f   <= tlrq_pkg::RST_L1_FLOOR;
            r_thr   <= tlrq_pkg::RST_THRESHOLD;
            r_boost <= tlrq_pkg::RST_BOOST;
            r_cap   <= tlrq_pkg::RST_CAP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tlrq_pkg::CFG_L2_FLOOR:  r_l2f   <= i_cfg_wdata[7:0];
                tlrq_pkg::CFG_L1_FLOOR:  r_l1f   <= i_cfg_wdata[7:0];
                tlrq_pkg::CFG_THRESHOLD: r_thr   <= i_cfg_wdata;
                tlrq_pkg::CFG_BOOST:     r_boost <= i_cfg_wdata[7:0];
                tlrq_pkg::CFG_CAP:       r_cap   <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // Request fields held for the length of the request.
    tlrq_pkg::t_kind r_kind;
    logic [15:0] r_id;
    logic [7:0]  r_prio, r_run_prio;
    logic [31:0] r_burst, r_wait, r_now, r_run_burst;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= tlrq_pkg::KIND_NONE;
        end else if (i_cmd.accept) begin
            r_kind <= tlrq_pkg::t_kind'(i_kind);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_id        <= i_task_id;
            r_prio      <= i_task_priority;
            r_burst     <= i_burst_estimate;
            r_wait      <= i_wait_so_far;
            r_now       <= i_now;
            r_run_prio  <= i_running_priority;
            r_run_burst <= i_running_burst;
        end
    end

    // Control state.
    logic [QUEUE_DEPTH-1:0] r_valid, r_live;
    logic [IDX_W-1:0]       r_idx, r_pipe_idx, r_best_idx;
    logic                   r_pipe_v, r_preempt, r_full;
    logic [1:0]             r_best_lvl;
    logic [15:0]            r_arr_ctr, r_cmp_ctr;
    tlrq_pkg::t_entry       r_rd, r_best;
    logic [31:0]            r_w;

    tlrq_pkg::t_entry r_mem [QUEUE_DEPTH];

    // Scan compare against the running best.
    logic [15:0] age_c, age_b;
    logic [1:0]  lvl_c;
    logic        ahead_same, take;

    always_comb begin
        age_c = r_cmp_ctr - r_rd.arrival;
        age_b = r_cmp_ctr - r_best.arrival;
        lvl_c = tlrq_pkg::level_of(r_rd.prio, r_l2f, r_l1f);
        ahead_same = (age_c > age_b);
        if (lvl_c == tlrq_pkg::LVL_ONE && r_rd.burst != r_best.burst) begin
            ahead_same = (r_rd.burst < r_best.burst);
        end else if (lvl_c == tlrq_pkg::LVL_TWO && r_rd.prio != r_best.prio) begin
            ahead_same = (r_rd.prio > r_best.prio);
        end
        take = r_pipe_v && r_live[r_pipe_idx] &&
               (r_best_lvl == tlrq_pkg::LVL_NONE || lvl_c < r_best_lvl ||
                (lvl_c == r_best_lvl && ahead_same));
    end

    // Aging update of the selected entry.
    logic [32:0] wsum;
    logic [8:0]  psum;
    logic        over;
    logic [7:0]  n_prio;
    logic [31:0] n_wait;

    always_comb begin
        wsum   = {1'b0, r_best.wait_acc} + {1'b0, r_now - r_best.enter};
        psum   = {1'b0, r_best.prio} + {1'b0, r_boost};
        over   = (r_w > {16'd0, r_thr});
        n_prio = r_best.prio;
        n_wait = r_w;
        if (over) begin
            n_prio = (psum > {1'b0, r_cap}) ? r_cap : psum[7:0];
            n_wait = r_w - {16'd0, r_thr};
        end
    end

    // Memory write port and the preempt check share one source mux.
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    tlrq_pkg::t_entry mem_wdata;
    logic             chk_hit;

    always_comb begin
        mem_we = i_cmd.ins_write | i_cmd.age_write;
        if (i_cmd.ins_write) begin
            mem_waddr = r_idx;
            mem_wdata = '{task_id: r_id, prio: r_prio, burst: r_burst, enter: r_now,
                          wait_acc: r_wait, arrival: r_arr_ctr};
        end else begin
            mem_waddr = r_best_idx;
            mem_wdata = '{task_id: r_best.task_id, prio: n_prio, burst: r_best.burst,
                          enter: r_now, wait_acc: n_wait, arrival: r_arr_ctr};
        end
        chk_hit = (tlrq_pkg::level_of(mem_wdata.prio, r_l2f, r_l1f) == tlrq_pkg::LVL_ONE) &&
                  (mem_wdata.burst < r_run_burst || r_run_prio < r_l1f);
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.scan_step) begin
            r_rd <= r_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_live     <= '0;
            r_idx      <= '0;
            r_pipe_v   <= 1'b0;
            r_best_lvl <= tlrq_pkg::LVL_NONE;
            r_arr_ctr  <= '0;
            r_preempt  <= 1'b0;
            r_full     <= 1'b0;
        end else begin
            r_pipe_v <= i_cmd.scan_step;
            if (i_cmd.accept) begin
                r_live     <= r_valid;
                r_idx      <= '0;
                r_best_lvl <= tlrq_pkg::LVL_NONE;
                r_full     <= 1'b0;
            end
            if (i_cmd.scan_start) begin
                r_idx      <= '0;
                r_best_lvl <= tlrq_pkg::LVL_NONE;
            end
            if (i_cmd.scan_step || i_cmd.idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end
            if (take) begin
                r_best_lvl <= lvl_c;
            end
            if (i_cmd.set_full) begin
                r_full <= 1'b1;
            end
            if (mem_we) begin
                r_arr_ctr <= r_arr_ctr + 16'd1;
                if (chk_hit) begin
                    r_preempt <= 1'b1;
                end
            end
            if (i_cmd.ins_write) begin
                r_valid[r_idx] <= 1'b1;
            end
            if (i_cmd.age_write) begin
                r_live[r_best_idx] <= 1'b0;
            end
            if (i_cmd.pick_take && r_best_lvl != tlrq_pkg::LVL_NONE) begin
                r_valid[r_best_idx] <= 1'b0;
                if (r_best_lvl == tlrq_pkg::LVL_ONE) begin
                    r_preempt <= 1'b0;
                end
            end
        end
    end

    // Ages stay relative to the counter as it stood when the request began,
    // so the aging order does not shift as entries take new arrival numbers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cmp_ctr <= r_arr_ctr;
        end
        if (r_pipe_v) begin
            r_pipe_idx <= r_idx;
        end else begin
            r_pipe_idx <= r_idx;
        end
        if (take) begin
            r_best     <= r_rd;
            r_best_idx <= r_pipe_idx;
        end
        if (i_cmd.age_calc) begin
            r_w <= wsum[32] ? 32'hFFFF_FFFF : wsum[31:0];
        end
    end

    // Result registers.
    logic found_now;
    assign found_now = (r_kind == tlrq_pkg::KIND_PICK) && (r_best_lvl != tlrq_pkg::LVL_NONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_found           <= found_now;
            o_picked_id       <= found_now ? r_best.task_id : 16'd0;
            o_picked_priority <= found_now ? r_best.prio : 8'd0;
            o_picked_wait     <= found_now ? r_best.wait_acc : 32'd0;
            o_picked_level    <= found_now ? r_best_lvl : tlrq_pkg::LVL_NONE;
            o_preempt         <= r_preempt;
            o_table_full      <= r_full;
        end
    end

    always_comb begin
        o_stat.slot_free = !r_valid[r_idx];
        o_stat.idx_last  = (r_idx == IDX_LAST);
        o_stat.best_hit  = (r_best_lvl != tlrq_pkg::LVL_NONE);
        o_stat.kind      = r_kind;
    end

endmodule

// ----- rtl/three_level_ready_queue_scheduler.sv -----
// Top level of the three-level ready queue scheduler.
//
//  channel   handshake                 payload
//  request   i_start / o_busy          i_kind, i_task_id, i_task_priority, i_burst_estimate,
//                                      i_wait_so_far, i_now, i_running_priority,
//                                      i_running_burst
//  result    o_done (one cycle)        o_found, o_picked_id, o_picked_priority, o_picked_wait,
//                                      o_picked_level, o_preempt, o_table_full
//  config    i_cfg_we                  i_cfg_idx, i_cfg_wdata
//
// A request is taken when i_start is high and o_busy is low; one result follows per request.
// Insert walks the valid bits for a free slot and writes it there, or flags a full table.
// Pick scans every slot through the single read port, then takes the best entry.
// Aging with k held entries rescans once per entry, aging the best remaining entry each time.
// Reset is synchronous and empties the table; the result side cannot stall.
module three_level_ready_queue_scheduler #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic [1:0]                        i_kind,
    input  logic [15:0]                       i_task_id,
    input  logic [7:0]                        i_task_priority,
    input  logic [31:0]                       i_burst_estimate,
    input  logic [31:0]                       i_wait_so_far,
    input  logic [31:0]                       i_now,
    input  logic [7:0]                        i_running_priority,
    input  logic [31:0]                       i_running_burst,
    input  logic                              i_cfg_we,
    input  logic [tlrq_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [tlrq_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    output logic                              o_done,
    output logic                              o_found,
    output logic [15:0]                       o_picked_id,
    output logic [7:0]                        o_picked_priority,
    output logic [31:0]                       o_picked_wait,
    output logic [1:0]                        o_picked_level,
    output logic                              o_preempt,
    output logic                              o_table_full
);

    tlrq_pkg::t_cmd    cmd;
    tlrq_pkg::t_status stat;

    tlrq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_kind  (i_kind),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    tlrq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_kind             (i_kind),
        .i_task_id          (i_task_id),
        .i_task_priority    (i_task_priority),
        .i_burst_estimate   (i_burst_estimate),
        .i_wait_so_far      (i_wait_so_far),
        .i_now              (i_now),
        .i_running_priority (i_running_priority),
        .i_running_burst    (i_running_burst),
        .o_done             (o_done),
        .o_found            (o_found),
        .o_picked_id        (o_picked_id),
        .o_picked_priority  (o_picked_priority),
        .o_picked_wait      (o_picked_wait),
        .o_picked_level     (o_picked_level),
        .o_preempt          (o_preempt),
        .o_table_full       (o_table_full)
    );

endmodule

// ----- rtl/tlrq_chk.sv -----
// Port-level checks for the scheduler, bound to the top level.
module tlrq_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_start,
    input logic        o_busy,
    input logic        o_done,
    input logic        o_found,
    input logic [15:0] o_picked_id,
    input logic [1:0]  o_picked_level,
    input logic        o_table_full
);

    // A taken request keeps the block busy in the next cycle.
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy |=> o_busy)
        else $error("busy not raised after a request was taken");

    // A result only appears once the request has finished.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy && $past(o_busy))
        else $error("result strobe outside the end of a request");

    // A found task always carries a real level, and a miss carries none.
    a_level_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_found == (o_picked_level != tlrq_pkg::LVL_NONE)))
        else $error("picked level disagrees with found");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_found |-> o_picked_id == 16'd0)
        else $error("picked id not zero on a miss");

    // A dropped insert never reports a picked task.
    a_full_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_table_full |-> !o_found)
        else $error("full and found in the same result");

endmodule

bind three_level_ready_queue_scheduler tlrq_chk u_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_start        (i_start),
    .o_busy         (o_busy),
    .o_done         (o_done),
    .o_found        (o_found),
    .o_picked_id    (o_picked_id),
    .o_picked_level (o_picked_level),
    .o_table_full   (o_table_full)
);

// ----- dv/three_level_ready_queue_scheduler_checker.sv -----
// Checker for the ready queue scheduler: predicts each request's result and compares it.
`timescale 1ns / 1ps
module three_level_ready_queue_scheduler_checker #(
    parameter int DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [1:0]  i_kind,
    input  logic [15:0] i_task_id,
    input  logic [7:0]  i_task_priority,
    input  logic [31:0] i_burst_estimate,
    input  logic [31:0] i_wait_so_far,
    input  logic [31:0] i_now,
    input  logic [7:0]  i_running_priority,
    input  logic [31:0] i_running_burst,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_done,
    input  logic        i_found,
    input  logic [15:0] i_picked_id,
    input  logic [7:0]  i_picked_priority,
    input  logic [31:0] i_picked_wait,
    input  logic [1:0]  i_picked_level,
    input  logic        i_preempt,
    input  logic        i_table_full,
    output int          o_errors,
    output int          o_pending,
    output int          o_picks_found,
    output int          o_full_seen
);

    typedef struct packed {
        logic        found;
        logic [15:0] id;
        logic [7:0]  prio;
        logic [31:0] wait_acc;
        logic [1:0]  level;
        logic        preempt;
        logic        full;
    } t_outcome;

    t_outcome    outcome_q[$];
    logic [7:0]  l2_floor, l1_floor, boost, cap;
    logic [15:0] threshold;
    logic        held[DEPTH];
    logic [15:0] t_id[DEPTH];
    logic [7:0]  t_prio[DEPTH];
    logic [31:0] t_burst[DEPTH];
    logic [31:0] t_enter[DEPTH];
    logic [31:0] t_wait[DEPTH];
    logic [15:0] t_arr[DEPTH];
    logic [15:0] arr_ctr;
    logic        preempt_flag;

    assign o_pending = outcome_q.size();

    function automatic int tier(logic [7:0] p);
        if (p < l2_floor) return 3;
        if (p < l1_floor) return 2;
        return 1;
    endfunction

    function automatic bool_ahead(int a, int b, int lvl);
        logic [15:0] age_a, age_b;
        age_a = arr_ctr - t_arr[a];
        age_b = arr_ctr - t_arr[b];
        if (lvl == 1 && t_burst[a] != t_burst[b]) return t_burst[a] < t_burst[b];
        if (lvl == 2 && t_prio[a] != t_prio[b]) return t_prio[a] > t_prio[b];
        return age_a > age_b;
    endfunction

    // Returns the best live slot, or -1; lvl is set to its tier.
    function automatic int best_slot(logic live[DEPTH], output int lvl);
        int b;
        for (int l = 1; l <= 3; l++) begin
            b = -1;
            for (int s = 0; s < DEPTH; s++) begin
                if (live[s] && tier(t_prio[s]) == l && (b < 0 || bool_ahead(s, b, l))) b = s;
            end
            if (b >= 0) begin
                lvl = l;
                return b;
            end
        end
        lvl = 0;
        return -1;
    endfunction

    task automatic restamp(int s, logic [31:0] now, logic [7:0] rp, logic [31:0] rb);
        t_enter[s] = now;
        t_arr[s] = arr_ctr;
        arr_ctr = arr_ctr + 16'd1;
        if (tier(t_prio[s]) == 1 && (t_burst[s] < rb || rp < l1_floor)) preempt_flag = 1'b1;
    endtask

    task automatic schedule_request();
        t_outcome    r;
        int          s, lvl, n;
        int          order[DEPTH];
        logic        live[DEPTH];
        logic [31:0] el, w;
        logic [8:0]  p;
        r = '0;
        case (tlrq_pkg::t_kind'(i_kind))
            tlrq_pkg::KIND_INSERT: begin
                s = -1;
                for (int k = 0; k < DEPTH; k++) if (!held[k] && s < 0) s = k;
                if (s < 0) begin
                    r.full = 1'b1;
                end else begin
                    held[s] = 1'b1;
                    t_id[s] = i_task_id;
                    t_prio[s] = i_task_priority;
                    t_burst[s] = i_burst_estimate;
                    t_wait[s] = i_wait_so_far;
                    restamp(s, i_now, i_running_priority, i_running_burst);
                end
            end
            tlrq_pkg::KIND_PICK: begin
                s = best_slot(held, lvl);
                if (s >= 0) begin
                    r.found = 1'b1;
                    r.id = t_id[s];
                    r.prio = t_prio[s];
                    r.wait_acc = t_wait[s];
                    r.level = lvl[1:0];
                    held[s] = 1'b0;
                    if (lvl == 1) preempt_flag = 1'b0;
                end
            end
            tlrq_pkg::KIND_AGE: begin
                live = held;
                n = 0;
                forever begin
                    s = best_slot(live, lvl);
                    if (s < 0) break;
                    order[n++] = s;
                    live[s] = 1'b0;
                end
                for (int k = 0; k < n; k++) begin
                    s = order[k];
                    el = i_now - t_enter[s];
                    w = t_wait[s] + el;
                    if (w < el) w = '1;
                    if (w > {16'd0, threshold}) begin
                        p = {1'b0, t_prio[s]} + {1'b0, boost};
                        if (p > {1'b0, cap}) p = {1'b0, cap};
                        t_prio[s] = p[7:0];
                        w = w - {16'd0, threshold};
                    end
                    t_wait[s] = w;
                    restamp(s, i_now, i_running_priority, i_running_burst);
                end
            end
            default: ;
        endcase
        r.preempt = preempt_flag;
        outcome_q.push_back(r);
    endtask

    always @(posedge i_clk) begin
        t_outcome e, a;
        if (!i_rst_n) begin
            l2_floor <= tlrq_pkg::RST_L2_FLOOR;
            l1_floor <= tlrq_pkg::RST_L1_FLOOR;
            threshold <= tlrq_pkg::RST_THRESHOLD;
            boost <= tlrq_pkg::RST_BOOST;
            cap <= tlrq_pkg::RST_CAP;
            for (int k = 0; k < DEPTH; k++) held[k] = 1'b0;
            arr_ctr = '0;
            preempt_flag = 1'b0;
            outcome_q.delete();
            o_errors <= 0;
            o_picks_found <= 0;
            o_full_seen <= 0;
        end else begin
            if (i_done) begin
                a = '{i_found, i_picked_id, i_picked_priority, i_picked_wait,
                      i_picked_level, i_preempt, i_table_full};
                if (outcome_q.size() == 0) begin
                    $display("%0t: result with no request waiting: %h", $time, a);
                    o_errors <= o_errors + 1;
                end else begin
                    e = outcome_q.pop_front();
                    if (e !== a) begin
                        $display("%0t: mismatch expected f=%b id=%h pr=%0d w=%h lv=%0d pe=%b fu=%b",
                                 $time, e.found, e.id, e.prio, e.wait_acc, e.level,
                                 e.preempt, e.full);
                        $display("%0t:          actual   f=%b id=%h pr=%0d w=%h lv=%0d pe=%b fu=%b",
                                 $time, a.found, a.id, a.prio, a.wait_acc, a.level,
                                 a.preempt, a.full);
                        o_errors <= o_errors + 1;
                    end
                    if (a.found) o_picks_found <= o_picks_found + 1;
                    if (a.full) o_full_seen <= o_full_seen + 1;
                end
            end
            if (i_start && !i_busy) schedule_request();
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    tlrq_pkg::CFG_L2_FLOOR:  l2_floor <= i_cfg_wdata[7:0];
                    tlrq_pkg::CFG_L1_FLOOR:  l1_floor <= i_cfg_wdata[7:0];
                    tlrq_pkg::CFG_THRESHOLD: threshold <= i_cfg_wdata;
                    tlrq_pkg::CFG_BOOST:     boost <= i_cfg_wdata[7:0];
                    tlrq_pkg::CFG_CAP:       cap <= i_cfg_wdata[7:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

// ----- dv/three_level_ready_queue_scheduler_tb.sv -----
// Stimulus and verdict for the three-level ready queue scheduler testbench.
`timescale 1ns / 1ps
module three_level_ready_queue_scheduler_tb;

    localparam int  DEPTH = 64;
    localparam longint CYCLE_LIMIT = 25000000;

    logic        clk, rst_n, start, busy, cfg_we, done;
    logic [1:0]  kind;
    logic [15:0] task_id;
    logic [7:0]  task_prio, run_prio;
    logic [31:0] burst, wait_in, now_tick, run_burst;
    logic [2:0]  cfg_idx;
    logic [15:0] cfg_wdata;
    logic        found, preempt, table_full;
    logic [15:0] picked_id;
    logic [7:0]  picked_prio;
    logic [31:0] picked_wait;
    logic [1:0]  picked_level;
    int          errors, pending, picks_found, full_seen;
    longint      cycles;
    int          requests_sent;
    logic [31:0] tick;

    three_level_ready_queue_scheduler #(.QUEUE_DEPTH(DEPTH)) DUT (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .o_busy(busy),
        .i_kind(kind), .i_task_id(task_id), .i_task_priority(task_prio),
        .i_burst_estimate(burst), .i_wait_so_far(wait_in), .i_now(now_tick),
        .i_running_priority(run_prio), .i_running_burst(run_burst),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_wdata(cfg_wdata),
        .o_done(done), .o_found(found), .o_picked_id(picked_id),
        .o_picked_priority(picked_prio), .o_picked_wait(picked_wait),
        .o_picked_level(picked_level), .o_preempt(preempt), .o_table_full(table_full)
    );

    three_level_ready_queue_scheduler_checker #(.DEPTH(DEPTH)) u_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .i_busy(busy),
        .i_kind(kind), .i_task_id(task_id), .i_task_priority(task_prio),
        .i_burst_estimate(burst), .i_wait_so_far(wait_in), .i_now(now_tick),
        .i_running_priority(run_prio), .i_running_burst(run_burst),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_wdata(cfg_wdata),
        .i_done(done), .i_found(found), .i_picked_id(picked_id),
        .i_picked_priority(picked_prio), .i_picked_wait(picked_wait),
        .i_picked_level(picked_level), .i_preempt(preempt), .i_table_full(table_full),
        .o_errors(errors), .o_pending(pending), .o_picks_found(picks_found),
        .o_full_seen(full_seen)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic logic [31:0] pick_word(int mode);
        case (mode)
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 3000);
            default: return $urandom;
        endcase
    endfunction

    // Issues one request and holds it until the block takes it.
    task automatic send_request(tlrq_pkg::t_kind k, logic [15:0] id, logic [7:0] pr,
                                logic [31:0] bu, logic [31:0] wt, logic [31:0] nw,
                                logic [7:0] rp, logic [31:0] rb);
        start <= 1'b1;
        kind <= k;
        task_id <= id;
        task_prio <= pr;
        burst <= bu;
        wait_in <= wt;
        now_tick <= nw;
        run_prio <= rp;
        run_burst <= rb;
        @(posedge clk);
        while (busy) @(posedge clk);
        start <= 1'b0;
        requests_sent++;
        // The block is busy for at least this cycle anyway.
        @(posedge clk);
    endtask

    task automatic random_request(int full_bias);
        int              sel;
        tlrq_pkg::t_kind k;
        logic [7:0]      pr;
        sel = $urandom_range(0, 99);
        if (sel < 50 + full_bias) k = tlrq_pkg::KIND_INSERT;
        else if (sel < 85) k = tlrq_pkg::KIND_PICK;
        else if (sel < 97) k = tlrq_pkg::KIND_AGE;
        else k = tlrq_pkg::KIND_NONE;
        tick = tick + $urandom_range(0, 800);
        if ($urandom_range(0, 30) == 0) tick = tick + $urandom;
        pr = ($urandom_range(0, 9) == 0) ? (($urandom_range(0, 1) != 0) ? 8'd149 : 8'd0)
                                         : 8'($urandom_range(0, 149));
        if ($urandom_range(0, 40) == 0) pr = 8'($urandom);
        send_request(k, 16'($urandom), pr,
                     ($urandom_range(0, 3) == 0) ? pick_word($urandom_range(0, 3))
                                                 : $urandom_range(0, 40),
                     pick_word($urandom_range(0, 3)), tick, 8'($urandom_range(0, 255)),
                     ($urandom_range(0, 1) != 0) ? $urandom_range(0, 40)
                                                 : pick_word($urandom_range(0, 3)));
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 70)) @(posedge clk);
    endtask

    // Waits for every outstanding result, then lets an aging pass worth of cycles go by.
    task automatic drain();
        while (pending != 0) @(posedge clk);
        repeat ((DEPTH + 2) * (DEPTH + 3) + 10) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    initial begin
        int burst_len;
        cycles = 0;
        requests_sent = 0;
        tick = 0;
        rst_n = 1'b0;
        start = 1'b0;
        kind = tlrq_pkg::KIND_NONE;
        task_id = '0;
        task_prio = '0;
        burst = '0;
        wait_in = '0;
        now_tick = '0;
        run_prio = '0;
        run_burst = '0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_wdata = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty pick, each level, tie on burst, preempt, boost with saturation.
        send_request(tlrq_pkg::KIND_PICK, 16'h0, 8'h0, 32'h0, 32'h0, 32'h0, 8'h0, 32'h0);
        send_request(tlrq_pkg::KIND_INSERT, 16'hFFFF, 8'd149, 32'd5, 32'hFFFF_FFFF, 32'd0,
                     8'd149, 32'd1);
        send_request(tlrq_pkg::KIND_INSERT, 16'h0001, 8'd100, 32'd5, 32'd0, 32'd10,
                     8'd99, 32'hFFFF_FFFF);
        send_request(tlrq_pkg::KIND_INSERT, 16'h0002, 8'd99, 32'd0, 32'd1400, 32'd20,
                     8'd0, 32'd0);
        send_request(tlrq_pkg::KIND_INSERT, 16'h0003, 8'd50, 32'hFFFF_FFFF, 32'd1, 32'd30,
                     8'd0, 32'd0);
        send_request(tlrq_pkg::KIND_INSERT, 16'h0004, 8'd0, 32'd7, 32'd1499, 32'd40,
                     8'd0, 32'd0);
        send_request(tlrq_pkg::KIND_INSERT, 16'h0005, 8'd49, 32'd7, 32'd0, 32'd50,
                     8'd0, 32'd0);
        send_request(tlrq_pkg::KIND_NONE, 16'h0, 8'h0, 32'h0, 32'h0, 32'd60, 8'h0, 32'h0);
        send_request(tlrq_pkg::KIND_AGE, 16'h0, 8'h0, 32'h0, 32'h0, 32'd2000, 8'd0, 32'd0);
        send_request(tlrq_pkg::KIND_AGE, 16'h0, 8'h0, 32'h0, 32'h0, 32'd1, 8'd149,
                     32'hFFFF_FFFF);
        repeat (7) send_request(tlrq_pkg::KIND_PICK, 16'h0, 8'h0, 32'h0, 32'h0, 32'h0,
                                8'h0, 32'h0);
        drain();

        // Random phases, each with its own register setting; fills the table now and then.
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: ;
                1: begin
                    write_reg(tlrq_pkg::CFG_L2_FLOOR, 16'd0);
                    write_reg(tlrq_pkg::CFG_L1_FLOOR, 16'd149);
                    write_reg(tlrq_pkg::CFG_THRESHOLD, 16'd0);
                    write_reg(tlrq_pkg::CFG_BOOST, 16'd149);
                    write_reg(tlrq_pkg::CFG_CAP, 16'd149);
                end
                2: begin
                    write_reg(tlrq_pkg::CFG_L2_FLOOR, 16'd149);
                    write_reg(tlrq_pkg::CFG_L1_FLOOR, 16'd0);
                    write_reg(tlrq_pkg::CFG_THRESHOLD, 16'hFFFF);
                    write_reg(tlrq_pkg::CFG_BOOST, 16'd0);
                    write_reg(tlrq_pkg::CFG_CAP, 16'd0);
                end
                default: begin
                    write_reg(tlrq_pkg::CFG_L2_FLOOR, 16'($urandom));
                    write_reg(tlrq_pkg::CFG_L1_FLOOR, 16'($urandom_range(0, 149)));
                    write_reg(tlrq_pkg::CFG_THRESHOLD, 16'($urandom_range(0, 4000)));
                    write_reg(tlrq_pkg::CFG_BOOST, 16'($urandom));
                    write_reg(tlrq_pkg::CFG_CAP, 16'($urandom_range(0, 255)));
                end
            endcase
            for (int n = 0; n < 135; n += burst_len) begin
                burst_len = $urandom_range(1, 20);
                for (int b = 0; b < burst_len; b++) random_request((phase % 3 == 1) ? 30 : 0);
                if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 150)) @(posedge clk);
            end
            drain();
        end

        $display("Sent %0d requests over eight register settings.", requests_sent);
        $display("Results with a task picked: %0d, inserts dropped on a full table: %0d.",
                 picks_found, full_seen);
        if (errors == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- three_level_ready_queue_scheduler.f -----
rtl/tlrq_pkg.sv
rtl/tlrq_ctrl.sv
rtl/tlrq_dp.sv
rtl/three_level_ready_queue_scheduler.sv
rtl/tlrq_chk.sv
dv/three_level_ready_queue_scheduler_checker.sv
dv/three_level_ready_queue_scheduler_tb.sv
